### src/twpo_pkg.sv
package twpo_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_E,
    ST_MUL_F,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_X,
    ST_MUL_C,
    ST_MUL_D,
    ST_DIV_Y,
    ST_PHASE,
    ST_CORDIC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SQUARE = 2'd1,
    SHAPE_TRI    = 2'd2,
    SHAPE_SAW    = 2'd3
  } shape_e;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_FREQ   = 3'd2,
    REG_TILT   = 3'd3,
    REG_SHAPE  = 3'd4,
    REG_START  = 3'd5,
    REG_FRAME  = 3'd6
  } reg_e;

  localparam int DIVW         = 51;
  localparam int CORDIC_STEPS = 24;
  localparam int MAX_DIM      = 4096;

  localparam logic [16:0] ONE_TILT  = 17'd65536;
  localparam logic [16:0] Q_QUARTER = 17'd16384;
  localparam logic [16:0] Q_HALF    = 17'd32768;
  localparam logic [16:0] Q_THREEQ  = 17'd49152;

  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic signed [16:0] SAMPLE_ONE = 17'sd16384;

  function automatic logic signed [33:0] cordic_angle(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sd536870912;
      5'd1:  a = 34'sd316933406;
      5'd2:  a = 34'sd167458907;
      5'd3:  a = 34'sd85004756;
      5'd4:  a = 34'sd42667331;
      5'd5:  a = 34'sd21354465;
      5'd6:  a = 34'sd10679838;
      5'd7:  a = 34'sd5340245;
      5'd8:  a = 34'sd2670163;
      5'd9:  a = 34'sd1335087;
      5'd10: a = 34'sd667544;
      5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;
      5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;
      5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;
      5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;
      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;
      5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;
      5'd23: a = 34'sd81;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

### src/tilted_wave_pixel_oscillator.sv
// Channel   Dir  Handshake              Payload
// pixel     in   in_valid_i/in_ready_o  pixel_x_i, pixel_y_i
// sample    out  out_valid_o/out_ready_i sample_value_o
// config    in   APB psel/penable/pwrite paddr, pwdata, prdata
//
// After a word is taken, in_ready_o stays low until its sample is loaded into the
// output register, so no new word is taken before the last is done: one shared 32x32
// multiplier runs six products, a bit-serial divider runs once for each of the two
// axis terms, and the CORDIC takes 24 steps.
// Reset: config registers go to their defaults, saw reference to zero.
// The last step holds while an earlier sample still waits at the output.
module tilted_wave_pixel_oscillator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [11:0]         pixel_x_i,
  input  logic [11:0]         pixel_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  sample_value_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import twpo_pkg::*;

  // config registers
  logic [12:0] width_q, height_q;
  logic [23:0] freq_q;
  logic [16:0] tilt_q;
  logic [1:0]  shape_q;
  logic [31:0] start_q;
  logic [15:0] frame_q;

  logic wr_en;
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd256;
      height_q <= 13'd256;
      freq_q   <= 24'd65536;
      tilt_q   <= 17'd0;
      shape_q  <= SHAPE_SINE;
      start_q  <= 32'd0;
      frame_q  <= 16'd0;
    end else if (wr_en) begin
      case (reg_e'(paddr[4:2]))
        REG_WIDTH:  width_q  <= pwdata[12:0];
        REG_HEIGHT: height_q <= pwdata[12:0];
        REG_FREQ:   freq_q   <= pwdata[23:0];
        REG_TILT:   tilt_q   <= pwdata[16:0];
        REG_SHAPE:  shape_q  <= pwdata[1:0];
        REG_START:  start_q  <= pwdata;
        REG_FRAME:  frame_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_WIDTH:  prdata = {19'd0, width_q};
      REG_HEIGHT: prdata = {19'd0, height_q};
      REG_FREQ:   prdata = {8'd0, freq_q};
      REG_TILT:   prdata = {15'd0, tilt_q};
      REG_SHAPE:  prdata = {30'd0, shape_q};
      REG_START:  prdata = start_q;
      REG_FRAME:  prdata = {16'd0, frame_q};
      default:    prdata = 32'd0;
    endcase
  end

  // static decode of the configuration
  logic [12:0] w_cl, h_cl;
  logic [11:0] xmax, ymax;
  logic        f_neg;
  logic [23:0] fmag;
  logic [16:0] tcl, pt, xa, ya, mmag;
  logic        half, mirror, m_neg;

  always_comb begin
    w_cl = (width_q < 13'd2) ? 13'd2 :
           (width_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : width_q;
    h_cl = (height_q < 13'd2) ? 13'd2 :
           (height_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : height_q;
    xmax = 12'(w_cl - 13'd1);
    ymax = 12'(h_cl - 13'd1);
    f_neg = freq_q[23];
    fmag  = f_neg ? (24'd0 - freq_q) : freq_q;
    tcl = (tilt_q > ONE_TILT) ? ONE_TILT : tilt_q;
    pt  = ONE_TILT - tcl;
    if (pt <= Q_QUARTER) begin
      ya = ONE_TILT - 17'(pt << 2); xa = 17'(pt << 2); half = 1'b0; mirror = 1'b0;
    end else if (pt <= Q_HALF) begin
      ya = 17'((pt - Q_QUARTER) << 2); xa = ONE_TILT - ya; half = 1'b0; mirror = 1'b1;
    end else if (pt <= Q_THREEQ) begin
      xa = 17'((pt - Q_HALF) << 2); ya = ONE_TILT - xa; half = 1'b1; mirror = 1'b0;
    end else begin
      ya = 17'((pt - Q_THREEQ) << 2); xa = ONE_TILT - ya; half = 1'b1; mirror = 1'b1;
    end
    // per-frame multiplier, kept as sign and magnitude
    if (tcl <= Q_QUARTER) begin
      mmag = ONE_TILT - 17'(tcl << 2); m_neg = 1'b0;
    end else if (tcl <= Q_HALF) begin
      mmag = 17'((tcl - Q_QUARTER) << 2); m_neg = 1'b1;
    end else if (tcl <= Q_THREEQ) begin
      mmag = ONE_TILT - 17'((tcl - Q_HALF) << 2); m_neg = 1'b0;
    end else begin
      mmag = 17'((tcl - Q_THREEQ) << 2); m_neg = 1'b1;
    end
  end

  // datapath state
  state_e state_q, state_d;
  logic [11:0] x_q, y_q, x_d, y_d;
  logic [63:0] prod_q, prod_d;
  logic [DIVW-1:0] dq_q, dq_d;
  logic [11:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] ph_q, ph_d;
  logic signed [33:0] cx_q, cy_q, z_q, cx_d, cy_d, z_d;
  logic signed [15:0] ref_q, ref_d;
  logic signed [15:0] out_q, out_d;
  logic        ov_q, ov_d;

  // shared multiplier
  logic [31:0] op_a, op_b;
  logic [63:0] mul_p;
  assign mul_p = op_a * op_b;

  // mirrored row as sign and magnitude
  logic        ry_neg;
  logic [11:0] rymag;
  always_comb begin
    ry_neg = mirror && (y_q > ymax);
    rymag  = ry_neg ? (y_q - ymax) : (mirror ? (ymax - y_q) : y_q);
  end

  // divider step
  logic [12:0] r_try, dvs;
  logic        ge;
  logic [DIVW-1:0] dq_nx;
  logic [31:0] q_lo;
  always_comb begin
    dvs   = {1'b0, (state_q == ST_DIV_Y) ? ymax : xmax};
    r_try = {rem_q, dq_q[DIVW-1]};
    ge    = (r_try >= dvs);
    dq_nx = {dq_q[DIVW-2:0], ge};
    q_lo  = neg_q ? (32'd0 - dq_nx[31:0]) : dq_nx[31:0];
  end

  // CORDIC step and phase fold
  logic signed [33:0] sh_x, sh_y, ang, z0, zf, ph_s;
  logic [31:0] ph_new;
  always_comb begin
    sh_x = cy_q >>> cnt_q[4:0];
    sh_y = cx_q >>> cnt_q[4:0];
    ang  = cordic_angle(cnt_q[4:0]);
    ph_new = acc_q + (half ? 32'h8000_0000 : 32'd0);
    ph_s = {{2{ph_new[31]}}, ph_new};
    z0   = ph_s;
    if (z0 > 34'sd1073741824)       zf = 34'sd2147483648 - z0;
    else if (z0 < -34'sd1073741824) zf = -34'sd2147483648 - z0;
    else                            zf = z0;
  end

  // final shaping
  logic signed [35:0] v, tri36, sin36;
  logic signed [15:0] tri_v;
  logic signed [16:0] tm, hv, av, bv, sv, res;
  logic        last, ref_upd;
  logic [32:0] q33;
  always_comb begin
    q33 = {1'b0, ph_q};
    if (q33 < 33'h0_4000_0000)      v = $signed({3'b0, q33} << 2);
    else if (q33 < 33'h0_C000_0000) v = 36'sh2_0000_0000 - $signed({3'b0, q33} << 2);
    else                            v = $signed({3'b0, q33} << 2) - 36'sh4_0000_0000;
    tri36 = 36'sd0 - ((v + 36'sd131072) >>> 18);
    tri_v = tri36[15:0];
    tm  = {tri_v[15], tri_v} - SAMPLE_ONE;
    hv  = tm >>> 1;
    av  = (tri_v <= ref_q) ? hv : (17'sd0 - hv);
    bv  = 17'sd0 - av;
    sin36 = {{2{cy_q[33]}}, cy_q} + 36'sd32768;
    sin36 = sin36 >>> 16;
    if (sin36 > 36'sd16384)       sv = SAMPLE_ONE;
    else if (sin36 < -36'sd16384) sv = -SAMPLE_ONE;
    else                          sv = sin36[16:0];
    last = (x_q == xmax);
    ref_upd = 1'b1;
    if (((pt == 17'd0) || (pt == ONE_TILT)) && last)  res = av;
    else if ((pt == Q_HALF) && last)                   res = bv;
    else if ((pt > 17'd0) && (pt < Q_HALF))            res = bv;
    else if ((pt > Q_HALF) && (pt < ONE_TILT))         res = av;
    else begin
      res = av; ref_upd = 1'b0;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = ov_q;
  assign sample_value_o = out_q;

  always_comb begin
    state_d = state_q;
    x_d = x_q; y_d = y_q;
    prod_d = prod_q; dq_d = dq_q; rem_d = rem_q; cnt_d = cnt_q;
    neg_d = neg_q; acc_d = acc_q; ph_d = ph_q;
    cx_d = cx_q; cy_d = cy_q; z_d = z_q;
    ref_d = ref_q; out_d = out_q;
    ov_d = ov_q && !out_ready_i;
    op_a = 32'd0; op_b = 32'd0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d = pixel_x_i; y_d = pixel_y_i;
          state_d = ST_MUL_E;
        end
      end
      ST_MUL_E: begin
        op_a = {8'd0, fmag}; op_b = {15'd0, mmag};
        prod_d = mul_p;
        state_d = ST_MUL_F;
      end
      ST_MUL_F: begin
        op_a = {16'd0, frame_q};
        op_b = (f_neg ^ m_neg) ? (32'd0 - prod_q[31:0]) : prod_q[31:0];
        prod_d = mul_p;
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        acc_d = start_q + prod_q[31:0];
        op_a = {20'd0, x_q}; op_b = {15'd0, xa};
        prod_d = mul_p;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        op_a = {3'd0, prod_q[28:0]}; op_b = {8'd0, fmag};
        dq_d = mul_p[DIVW-1:0]; rem_d = 12'd0; cnt_d = 6'd0;
        neg_d = f_neg;
        state_d = ST_DIV_X;
      end
      ST_DIV_X, ST_DIV_Y: begin
        dq_d  = dq_nx;
        rem_d = ge ? 12'(r_try - dvs) : r_try[11:0];
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIVW - 1)) begin
          acc_d = acc_q + q_lo;
          state_d = (state_q == ST_DIV_X) ? ST_MUL_C : ST_PHASE;
        end
      end
      ST_MUL_C: begin
        op_a = {20'd0, rymag}; op_b = {15'd0, ya};
        prod_d = mul_p;
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        op_a = {3'd0, prod_q[28:0]}; op_b = {8'd0, fmag};
        dq_d = mul_p[DIVW-1:0]; rem_d = 12'd0; cnt_d = 6'd0;
        neg_d = f_neg ^ ry_neg;
        state_d = ST_DIV_Y;
      end
      ST_PHASE: begin
        ph_d = ph_new;
        cx_d = CORDIC_K; cy_d = 34'sd0; z_d = zf; cnt_d = 6'd0;
        state_d = (shape_e'(shape_q) == SHAPE_SINE) ? ST_CORDIC : ST_DONE;
      end
      ST_CORDIC: begin
        if (!z_q[33]) begin
          cx_d = cx_q - sh_x; cy_d = cy_q + sh_y; z_d = z_q - ang;
        end else begin
          cx_d = cx_q + sh_x; cy_d = cy_q - sh_y; z_d = z_q + ang;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          state_d = ST_IDLE;
          case (shape_e'(shape_q))
            SHAPE_SINE:   out_d = sv[15:0];
            SHAPE_SQUARE: out_d = (ph_q <= 32'h8000_0000) ? 16'sd16384 : -16'sd16384;
            SHAPE_TRI:    out_d = tri_v;
            SHAPE_SAW: begin
              out_d = res[15:0];
              if (ref_upd) ref_d = tri_v;
            end
            default: out_d = 16'sd0;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      ref_q   <= 16'sd0;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      ref_q   <= ref_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d;
    prod_q <= prod_d; dq_q <= dq_d; rem_q <= rem_d;
    neg_q <= neg_d; acc_q <= acc_d; ph_q <= ph_d;
    cx_q <= cx_d; cy_q <= cy_d; z_q <= z_d;
    out_q <= out_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready high right after a word was taken");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_value_o <= 16'sd16384) && (sample_value_o >= -16'sd16384))
    else $error("sample out of range");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV_X) || (state_q == ST_DIV_Y)) |-> (cnt_q < 6'(DIVW)))
    else $error("divider count overrun");

  a_cordic_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORDIC) |-> (cnt_q < 6'(CORDIC_STEPS)))
    else $error("cordic count overrun");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import twpo_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int IDLE_PCT    = 31;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int RAND_ITEMS  = 730;

  typedef bit bool_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [11:0]        pixel_x_i = '0;
  logic [11:0]        pixel_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] sample_value_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  tilted_wave_pixel_oscillator dut (.*);

  always #CLK_HALF clk_i = ~clk_i;

  // predictor copy of the register file and state
  logic [12:0]        img_w, img_h;
  logic signed [23:0] freq;
  logic [16:0]        tilt;
  logic [1:0]         shape;
  logic [31:0]        start_ph;
  logic [15:0]        frame_no;
  logic [31:0]        frame_ofs;
  logic signed [31:0] saw_ref;

  logic signed [15:0] sample_q[$];
  int                 err_cnt = 0;
  int                 idle_cnt = 0;
  bool_t              calm;

  task automatic report(input string what, input logic signed [15:0] got,
                        input logic signed [15:0] exp_v);
    $display("mismatch %s: got %0d exp %0d at %0t", what, got, exp_v, $realtime);
    err_cnt++;
  endtask

  function automatic longint sra(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint tilt_sat();
    return (tilt > ONE_TILT) ? longint'(ONE_TILT) : longint'(tilt);
  endfunction

  function automatic longint dim_sat(input logic [12:0] d);
    if (d < 2) return 2;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic void refresh_offset();
    longint t, m;
    logic [63:0] adv, tot;
    t = tilt_sat();
    if (t <= 16384)      m = 65536 - 4 * t;
    else if (t <= 32768) m = -4 * (t - 16384);
    else if (t <= 49152) m = 65536 - 4 * (t - 32768);
    else                 m = -4 * (t - 49152);
    adv = longint'(freq) * m;
    tot = 64'(start_ph) + 64'(frame_no) * adv;
    frame_ofs = tot[31:0];
  endfunction

  function automatic longint sine_of(input logic [31:0] p);
    longint z, cx, cy, dx, dy, r;
    z = p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
    cx = CORDIC_K;
    cy = 0;
    if (z > 1073741824) z = 64'sd2147483648 - z;
    else if (z < -1073741824) z = -64'sd2147483648 - z;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = sra(cy, i);
      dy = sra(cx, i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= cordic_angle(5'(i));
      end else begin
        cx += dx; cy -= dy; z += cordic_angle(5'(i));
      end
    end
    r = rnd_shift(cy, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic longint inv_tri(input logic [31:0] p);
    longint q, v;
    q = longint'(p);
    if (q < 1073741824) v = 4 * q;
    else if (q < 64'sd3221225472) v = 64'sd8589934592 - 4 * q;
    else v = 4 * q - 64'sd17179869184;
    return -rnd_shift(v, 18);
  endfunction

  function automatic logic signed [15:0] wave_sample(input logic [11:0] px,
                                                     input logic [11:0] py);
    longint w, hg, pt, xa, ya, ry, x, y, term, res, t, hh, a;
    bit half, mirror, last;
    logic [31:0] ph;
    x = px;
    y = py;
    w = dim_sat(img_w);
    hg = dim_sat(img_h);
    pt = 65536 - tilt_sat();
    if (pt <= 16384) begin
      ya = 65536 - 4 * pt; xa = 4 * pt; half = 0; mirror = 0;
    end else if (pt <= 32768) begin
      ya = 4 * (pt - 16384); xa = 65536 - ya; half = 0; mirror = 1;
    end else if (pt <= 49152) begin
      xa = 4 * (pt - 32768); ya = 65536 - xa; half = 1; mirror = 0;
    end else begin
      ya = 4 * (pt - 49152); xa = 65536 - ya; half = 1; mirror = 1;
    end
    ry = mirror ? (hg - 1) - y : y;
    // SV signed division truncates toward zero, as required
    term = (x * xa * longint'(freq)) / (w - 1) + (ry * ya * longint'(freq)) / (hg - 1);
    ph = term[31:0] + frame_ofs + (half ? 32'h8000_0000 : 32'h0);
    case (shape_e'(shape))
      SHAPE_SINE:   res = sine_of(ph);
      SHAPE_SQUARE: res = (ph <= 32'h8000_0000) ? 16384 : -16384;
      SHAPE_TRI:    res = inv_tri(ph);
      default: begin
        t = inv_tri(ph);
        hh = sra(t - 16384, 1);
        a = (t <= longint'(saw_ref)) ? hh : -hh;
        last = (x == w - 1);
        if ((pt == 0 || pt == 65536) && last) begin
          saw_ref = 32'(t); res = a;
        end else if (pt == 32768 && last) begin
          saw_ref = 32'(t); res = -a;
        end else if (pt > 0 && pt < 32768) begin
          saw_ref = 32'(t); res = -a;
        end else if (pt > 32768 && pt < 65536) begin
          saw_ref = 32'(t); res = a;
        end else begin
          res = a;
        end
      end
    endcase
    return res[15:0];
  endfunction

  task automatic reg_write(input reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  img_w = val[12:0];
      REG_HEIGHT: img_h = val[12:0];
      REG_FREQ:   freq = val[23:0];
      REG_TILT:   tilt = val[16:0];
      REG_SHAPE:  shape = val[1:0];
      REG_START:  start_ph = val;
      default:    frame_no = val[15:0];
    endcase
    refresh_offset();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // pixel word; exp_v checked only when has_exp is set
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                            input bit has_exp, input logic signed [15:0] exp_v);
    logic signed [15:0] pred;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (!in_ready_o);
    pred = wave_sample(px, py);
    if (has_exp && pred !== exp_v) report("table", pred, exp_v);
    sample_q.push_back(pred);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sample_q.size() == 0) report("unexpected", sample_value_o, 16'sd0);
        else begin
          if (sample_value_o !== sample_q[0])
            report("sample", sample_value_o, sample_q[0]);
          void'(sample_q.pop_front());
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  typedef struct {
    logic [11:0]        x;
    logic [11:0]        y;
    bit                 has_exp;
    logic signed [15:0] exp_v;
  } pix_row_t;

  pix_row_t dir_tab[6] = '{
    '{12'd0, 12'd0, 1'b1, 16'sd0},        // reset defaults, half-turn phase: sine 0
    '{12'd255, 12'd0, 1'b0, 16'sd0},
    '{12'd0, 12'd255, 1'b0, 16'sd0},
    '{12'd64, 12'd17, 1'b0, 16'sd0},
    '{12'd4095, 12'd4095, 1'b0, 16'sd0},  // outside the image
    '{12'd128, 12'd0, 1'b0, 16'sd0}
  };

  initial begin
    logic [11:0] px, py;
    int wmax, hmax;
    calm = 1'b0;
    img_w = 13'd256; img_h = 13'd256; freq = 24'sd65536; tilt = '0;
    shape = '0; start_ph = '0; frame_no = '0; saw_ref = 0;
    refresh_offset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each shape over the table, then the tilt corners
    for (int s = 0; s < 4; s++) begin
      if (s != 0) reg_write(REG_SHAPE, 32'(s));
      foreach (dir_tab[i])
        send_pixel(dir_tab[i].x, dir_tab[i].y, (s == 0) && dir_tab[i].has_exp,
                   dir_tab[i].exp_v);
      wait_drained();
    end
    reg_write(REG_WIDTH, 32'd4096);
    reg_write(REG_HEIGHT, 32'd2);
    reg_write(REG_FREQ, 32'h80_0000);
    reg_write(REG_START, 32'hFFFF_FFFF);
    reg_write(REG_FRAME, 32'hFFFF);
    foreach (dir_tab[i]) if (i < 3) send_pixel(dir_tab[i].x, dir_tab[i].y, 0, 0);
    wait_drained();
    reg_write(REG_TILT, 32'h1FFFF);  // above one, clamped
    send_pixel(12'd4095, 12'd1, 0, 0);
    wait_drained();

    // random phases; the fourth runs with no idling at all
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 3);
      case ($urandom_range(3))
        0: reg_write(REG_WIDTH, $urandom_range(8191));
        1: reg_write(REG_WIDTH, $urandom_range(2, 64));
        default: reg_write(REG_WIDTH, $urandom_range(2, 4096));
      endcase
      reg_write(REG_HEIGHT, (ph == 1) ? 32'd4096 : $urandom_range(8191));
      reg_write(REG_FREQ, $urandom);
      case ($urandom_range(4))
        0: reg_write(REG_TILT, 32'(Q_HALF));
        1: reg_write(REG_TILT, 32'($urandom_range(4) * 16384));
        2: reg_write(REG_TILT, $urandom_range(131071));
        default: reg_write(REG_TILT, $urandom_range(65536));
      endcase
      reg_write(REG_SHAPE, (ph < 4) ? 32'(ph) : $urandom_range(3));
      reg_write(REG_START, $urandom);
      reg_write(REG_FRAME, (ph == 2) ? 32'h0 : $urandom);
      wmax = int'(dim_sat(img_w)) - 1;
      hmax = int'(dim_sat(img_h)) - 1;
      for (int k = 0; k < RAND_ITEMS / 10; k++) begin
        if ($urandom_range(9) == 0) begin
          px = 12'($urandom); py = 12'($urandom);
        end else begin
          px = (wmax > 4095) ? 12'($urandom) : 12'($urandom_range(wmax));
          py = (hmax > 4095) ? 12'($urandom) : 12'($urandom_range(hmax));
          if ($urandom_range(7) == 0) px = 12'(wmax);
        end
        send_pixel(px, py, 0, 0);
      end
      wait_drained();
    end

    calm = 1'b0;
    if (err_cnt == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
